// ----- rtl/tksd_pkg.sv -----
package tksd_pkg;

  typedef struct packed {
    logic       eoi;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] key_code;
    logic [7:0] char_value;
  } result_t;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_KEY     = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_EOI     = 2'd3;

  localparam logic [5:0] KC_BACKSPACE        = 6'd0;
  localparam logic [5:0] KC_TAB              = 6'd1;
  localparam logic [5:0] KC_ENTER            = 6'd2;
  localparam logic [5:0] KC_ESC              = 6'd3;
  localparam logic [5:0] KC_END              = 6'd4;
  localparam logic [5:0] KC_HOME             = 6'd5;
  localparam logic [5:0] KC_F1               = 6'd6;
  localparam logic [5:0] KC_F3               = 6'd7;
  localparam logic [5:0] KC_F5               = 6'd8;
  localparam logic [5:0] KC_INS              = 6'd9;
  localparam logic [5:0] KC_DEL              = 6'd10;
  localparam logic [5:0] KC_PGUP             = 6'd11;
  localparam logic [5:0] KC_PGDN             = 6'd12;
  localparam logic [5:0] KC_SHIFT_CTRL_UP    = 6'd13;
  localparam logic [5:0] KC_SHIFT_UP         = 6'd14;
  localparam logic [5:0] KC_CTRL_UP          = 6'd15;
  localparam logic [5:0] KC_UP               = 6'd16;
  localparam logic [5:0] KC_SHIFT_CTRL_DOWN  = 6'd17;
  localparam logic [5:0] KC_SHIFT_DOWN       = 6'd18;
  localparam logic [5:0] KC_CTRL_DOWN        = 6'd19;
  localparam logic [5:0] KC_DOWN             = 6'd20;
  localparam logic [5:0] KC_SHIFT_CTRL_RIGHT = 6'd21;
  localparam logic [5:0] KC_SHIFT_RIGHT      = 6'd22;
  localparam logic [5:0] KC_CTRL_RIGHT       = 6'd23;
  localparam logic [5:0] KC_RIGHT            = 6'd24;
  localparam logic [5:0] KC_SHIFT_CTRL_LEFT  = 6'd25;
  localparam logic [5:0] KC_SHIFT_LEFT       = 6'd26;
  localparam logic [5:0] KC_CTRL_LEFT        = 6'd27;
  localparam logic [5:0] KC_LEFT             = 6'd28;
  localparam logic [5:0] KC_SHIFT_CTRL_END   = 6'd29;
  localparam logic [5:0] KC_SHIFT_END        = 6'd30;
  localparam logic [5:0] KC_CTRL_END         = 6'd31;
  localparam logic [5:0] KC_SHIFT_CTRL_HOME  = 6'd32;
  localparam logic [5:0] KC_SHIFT_HOME       = 6'd33;
  localparam logic [5:0] KC_CTRL_HOME        = 6'd34;
  localparam logic [5:0] KC_SHIFT_TAB        = 6'd35;
  localparam logic [5:0] KC_CTRL_TAB         = 6'd36;
  localparam logic [5:0] KC_SHIFT_PGUP       = 6'd37;
  localparam logic [5:0] KC_SHIFT_PGDN       = 6'd38;
  localparam logic [5:0] KC_NONE             = 6'd63;

endpackage

// ----- rtl/tksd_in_stage.sv -----
module tksd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_end_of_input,
  input  logic           take,
  output logic           item_valid,
  output tksd_pkg::item_t item
);
  import tksd_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_stall   = valid_r && !take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.data <= in_byte;
      item_r.eoi  <= in_end_of_input;
    end
  end

endmodule

// ----- rtl/tksd_decode.sv -----
module tksd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  tksd_pkg::item_t   item,
  input  logic              out_free,
  output logic              take,
  output logic              load,
  output tksd_pkg::result_t result
);
  import tksd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ESC   = 4'd1,
    PH_SS3   = 4'd2,
    PH_CSI   = 4'd3,
    PH_CSI1  = 4'd4,
    PH_MOD   = 4'd5,
    PH_FINAL = 4'd6,
    PH_TILDE = 4'd7,
    PH_EXT   = 4'd8
  } phase_t;

  localparam logic [7:0] B_NUL   = 8'h00;
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_ESC   = 8'h1B;
  localparam logic [7:0] B_ONE   = 8'h31;
  localparam logic [7:0] B_TWO   = 8'h32;
  localparam logic [7:0] B_FIVE  = 8'h35;
  localparam logic [7:0] B_SIX   = 8'h36;
  localparam logic [7:0] B_SEMI  = 8'h3B;
  localparam logic [7:0] B_SS3   = 8'h4F;
  localparam logic [7:0] B_CSI   = 8'h5B;
  localparam logic [7:0] B_TILDE = 8'h7E;
  localparam logic [7:0] B_DEL   = 8'h7F;
  localparam logic [7:0] B_EXT   = 8'hE0;

  function automatic result_t key_result(input logic [5:0] key);
    result_t r;
    r = '0;
    if (key == KC_NONE) begin
      r.kind = KIND_UNKNOWN;
    end else begin
      r.kind     = KIND_KEY;
      r.key_code = key;
    end
    return r;
  endfunction

  function automatic logic [5:0] pick_mod(input logic sh, input logic ct,
                                          input logic [5:0] k_sc, input logic [5:0] k_s,
                                          input logic [5:0] k_c, input logic [5:0] k_p);
    logic [5:0] k;
    if (sh && ct) k = k_sc;
    else if (sh)  k = k_s;
    else if (ct)  k = k_c;
    else          k = k_p;
    return k;
  endfunction

  function automatic logic [5:0] digit_key(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h31:   k = KC_HOME;
      8'h32:   k = KC_INS;
      8'h33:   k = KC_DEL;
      8'h34:   k = KC_END;
      8'h35:   k = KC_PGUP;
      default: k = KC_PGDN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] csi_letter(input logic [7:0] b, input logic sh,
                                            input logic ct);
    logic [5:0] k;
    case (b)
      8'h41: k = pick_mod(sh, ct, KC_SHIFT_CTRL_UP, KC_SHIFT_UP, KC_CTRL_UP, KC_UP);
      8'h42: k = pick_mod(sh, ct, KC_SHIFT_CTRL_DOWN, KC_SHIFT_DOWN, KC_CTRL_DOWN,
                          KC_DOWN);
      8'h43: k = pick_mod(sh, ct, KC_SHIFT_CTRL_RIGHT, KC_SHIFT_RIGHT, KC_CTRL_RIGHT,
                          KC_RIGHT);
      8'h44: k = pick_mod(sh, ct, KC_SHIFT_CTRL_LEFT, KC_SHIFT_LEFT, KC_CTRL_LEFT,
                          KC_LEFT);
      8'h46: k = pick_mod(sh, ct, KC_SHIFT_CTRL_END, KC_SHIFT_END, KC_CTRL_END, KC_END);
      8'h48: k = pick_mod(sh, ct, KC_SHIFT_CTRL_HOME, KC_SHIFT_HOME, KC_CTRL_HOME,
                          KC_HOME);
      8'h5A: k = KC_SHIFT_TAB;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] ss3_key(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h46:   k = KC_END;
      8'h48:   k = KC_HOME;
      8'h50:   k = KC_F1;
      8'h52:   k = KC_F3;
      8'h54:   k = KC_F5;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] ext_key(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h0F: k = KC_SHIFT_TAB;
      8'h3B: k = KC_F1;
      8'h3D: k = KC_F3;
      8'h3F: k = KC_F5;
      8'h47: k = KC_HOME;
      8'h48: k = KC_UP;
      8'h49: k = KC_PGUP;
      8'h4B: k = KC_LEFT;
      8'h4D: k = KC_RIGHT;
      8'h4F: k = KC_END;
      8'h50: k = KC_DOWN;
      8'h51: k = KC_PGDN;
      8'h52: k = KC_INS;
      8'h53: k = KC_DEL;
      8'h73: k = KC_CTRL_LEFT;
      8'h74: k = KC_CTRL_RIGHT;
      8'h75: k = KC_CTRL_END;
      8'h77: k = KC_CTRL_HOME;
      8'h8D: k = KC_CTRL_UP;
      8'h91: k = KC_CTRL_DOWN;
      8'h94: k = KC_CTRL_TAB;
      8'hB8: k = KC_SHIFT_UP;
      8'hB7: k = KC_SHIFT_HOME;
      8'hBF: k = KC_SHIFT_END;
      8'hB9: k = KC_SHIFT_PGUP;
      8'hBB: k = KC_SHIFT_LEFT;
      8'hBD: k = KC_SHIFT_RIGHT;
      8'hC0: k = KC_SHIFT_DOWN;
      8'hC1: k = KC_SHIFT_PGDN;
      8'hDB: k = KC_SHIFT_CTRL_LEFT;
      8'hDD: k = KC_SHIFT_CTRL_RIGHT;
      8'hD8: k = KC_SHIFT_CTRL_UP;
      8'hE0: k = KC_SHIFT_CTRL_DOWN;
      8'hD7: k = KC_SHIFT_CTRL_HOME;
      8'hDF: k = KC_SHIFT_CTRL_END;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic       shift_r, shift_nxt;
  logic       ctrl_r, ctrl_nxt;
  logic [5:0] pend_r, pend_nxt;
  logic       emit;
  result_t    res;

  always_comb begin
    emit      = 1'b0;
    res       = '0;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    pend_nxt  = pend_r;
    if (item.eoi) begin
      emit      = 1'b1;
      phase_nxt = PH_IDLE;
      if (phase_r == PH_IDLE) begin
        res.kind = KIND_EOI;
      end else begin
        res = key_result(KC_NONE);
      end
    end else begin
      case (phase_r)
        PH_ESC: begin
          if (item.data == B_ESC) begin
            emit      = 1'b1;
            res       = key_result(KC_ESC);
            phase_nxt = PH_IDLE;
          end else if (item.data == B_SS3) begin
            phase_nxt = PH_SS3;
          end else if (item.data == B_CSI) begin
            shift_nxt = 1'b0;
            ctrl_nxt  = 1'b0;
            phase_nxt = PH_CSI;
          end else begin
            emit      = 1'b1;
            res       = key_result(KC_NONE);
            phase_nxt = PH_IDLE;
          end
        end
        PH_SS3: begin
          emit      = 1'b1;
          res       = key_result(ss3_key(item.data));
          phase_nxt = PH_IDLE;
        end
        PH_CSI, PH_FINAL: begin
          if (phase_r == PH_CSI && item.data == B_ONE) begin
            phase_nxt = PH_CSI1;
          end else if (item.data >= B_ONE && item.data <= B_SIX) begin
            pend_nxt  = digit_key(item.data);
            phase_nxt = PH_TILDE;
          end else begin
            emit      = 1'b1;
            res       = key_result(csi_letter(item.data, shift_r, ctrl_r));
            phase_nxt = PH_IDLE;
          end
        end
        PH_CSI1: begin
          if (item.data == B_TILDE) begin
            emit      = 1'b1;
            res       = key_result(KC_HOME);
            phase_nxt = PH_IDLE;
          end else if (item.data == B_SEMI) begin
            phase_nxt = PH_MOD;
          end else begin
            emit      = 1'b1;
            res       = key_result(KC_NONE);
            phase_nxt = PH_IDLE;
          end
        end
        PH_MOD: begin
          if (item.data == B_TWO || item.data == B_SIX) shift_nxt = 1'b1;
          if (item.data == B_FIVE || item.data == B_SIX) ctrl_nxt = 1'b1;
          phase_nxt = PH_FINAL;
        end
        PH_TILDE: begin
          emit      = 1'b1;
          res       = key_result((item.data == B_TILDE) ? pend_r : KC_NONE);
          phase_nxt = PH_IDLE;
        end
        PH_EXT: begin
          emit      = 1'b1;
          res       = key_result(ext_key(item.data));
          phase_nxt = PH_IDLE;
        end
        default: begin
          case (item.data)
            B_BS, B_DEL: begin
              emit = 1'b1;
              res  = key_result(KC_BACKSPACE);
            end
            B_TAB: begin
              emit = 1'b1;
              res  = key_result(KC_TAB);
            end
            B_CR, B_LF: begin
              emit = 1'b1;
              res  = key_result(KC_ENTER);
            end
            B_ESC: begin
              phase_nxt = PH_ESC;
            end
            B_NUL, B_EXT: begin
              phase_nxt = PH_EXT;
            end
            default: begin
              emit           = 1'b1;
              res.kind       = KIND_CHAR;
              res.char_value = item.data;
            end
          endcase
        end
      endcase
    end
  end

  assign take   = item_valid && (!emit || out_free);
  assign load   = take && emit;
  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      pend_r  <= 6'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.eoi |-> emit)
    else $error("end of input did not produce a result");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> phase_r == PH_IDLE)
    else $error("parser not idle after a completed sequence");

  a_pending_named: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TILDE |-> pend_r != KC_NONE && pend_r <= KC_PGDN)
    else $error("pending key out of range while waiting for tilde");

endmodule

// ----- rtl/tksd_out_stage.sv -----
module tksd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tksd_pkg::result_t result,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [5:0]        out_key_code,
  output logic [7:0]        out_char_value
);
  import tksd_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free       = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_kind       = res_r.kind;
  assign out_key_code   = res_r.key_code;
  assign out_char_value = res_r.char_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  a_key_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.kind != KIND_KEY |-> res_r.key_code == 6'd0)
    else $error("key code set on a result that is not a named key");

  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.kind != KIND_CHAR |-> res_r.char_value == 8'd0)
    else $error("character set on a result that is not a character");

endmodule

// ----- rtl/terminal_key_sequence_decoder_unit.sv -----
// Decodes a keyboard byte stream into key events: plain characters, named keys
// (escape sequences ESC ESC, ESC O x, ESC [ x, ESC [ digit ~, ESC [ 1 ; mod x,
// and the 0x00/0xE0 extended codes), unknown sequences, and end of input. A
// transaction can be accepted every cycle; the input stalls only while a finished
// result waits in the output register behind out_stall, and in_stall follows
// out_stall in the same cycle. A byte that continues an open sequence yields no
// result, and every completed sequence yields exactly one. A result reaches the
// out_ ports through the input register and the output register: the byte sits
// in the input register while the combinational parser computes the result,
// which loads the output register once that register is free. The parser state
// update is the only loop.
module terminal_key_sequence_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [5:0] out_key_code,
  output logic [7:0] out_char_value
);
  import tksd_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    load;
  logic    out_free;
  result_t result;

  tksd_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .take            (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  tksd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .load       (load),
    .result     (result)
  );

  tksd_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .result         (result),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_key_code   (out_key_code),
    .out_char_value (out_char_value)
  );

endmodule
